FILE: hw/rtl/hdd_pkg.sv
// ----------------------------------------------------------------------------
// hdd_pkg
// Shared types for the Hermite divided-difference table core.
// ----------------------------------------------------------------------------
package hdd_pkg;

  typedef enum logic [1:0] {
    FAULT_OK   = 2'd0,
    FAULT_SAT  = 2'd1,
    FAULT_ZERO = 2'd2
  } fault_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SLOT,
    ST_DIV
  } state_t;

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_RUN,
    DV_FIN
  } div_state_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] value;
    fault_t             fault;
  } div_res_t;

endpackage

FILE: hw/rtl/hdd_cell.sv
// ----------------------------------------------------------------------------
// hdd_cell
// One slot of the rotating row chain: takes its neighbor's word or a new one.
// ----------------------------------------------------------------------------
module hdd_cell (
  input  logic        clk,
  input  logic        en,
  input  logic        load,
  input  logic [31:0] load_data,
  input  logic [31:0] nb_data,
  output logic [31:0] q
);

  always_ff @(posedge clk) begin
    if (en) begin
      q <= load ? load_data : nb_data;
    end
  end

endmodule

FILE: hw/rtl/hdd_divider.sv
// ----------------------------------------------------------------------------
// hdd_divider
// Bit-serial signed fixed-point divider with saturation and zero check.
// ----------------------------------------------------------------------------
module hdd_divider #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic signed [32:0]  num,
  input  logic signed [32:0]  den,
  output hdd_pkg::div_res_t   res
);
  import hdd_pkg::*;

  localparam int DW = 33 + FRAC_BITS;
  localparam int CW = $clog2(DW + 1);

  div_state_t     state, state_next;
  logic [DW-1:0]  qr;
  logic [32:0]    rem;
  logic [32:0]    dvs;
  logic           neg;
  logic           zero;
  logic [CW-1:0]  cnt;
  logic [33:0]    trial;
  logic [32:0]    num_mag;
  logic [32:0]    den_mag;
  logic           pos_ovf;
  logic           neg_ovf;

  always_comb begin
    num_mag = num[32] ? 33'(-num) : 33'(num);
    den_mag = den[32] ? 33'(-den) : 33'(den);
    trial   = {rem, qr[DW-1]} - {1'b0, dvs};
    pos_ovf = |qr[DW-1:31];
    neg_ovf = (|qr[DW-1:32]) | (qr[31] & (|qr[30:0]));
  end

  always_comb begin
    state_next = state;
    unique case (state)
      DV_IDLE: if (start) state_next = (den == '0) ? DV_FIN : DV_RUN;
      DV_RUN:  if (cnt == CW'(1)) state_next = DV_FIN;
      DV_FIN:  state_next = DV_IDLE;
      default: state_next = DV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == DV_IDLE && start) begin
      qr   <= DW'(num_mag) << FRAC_BITS;
      rem  <= '0;
      dvs  <= den_mag;
      neg  <= num[32] ^ den[32];
      zero <= (den == '0);
      cnt  <= CW'(DW);
    end else if (state == DV_RUN) begin
      if (!trial[33]) begin
        rem <= trial[32:0];
        qr  <= {qr[DW-2:0], 1'b1};
      end else begin
        rem <= {rem[31:0], qr[DW-1]};
        qr  <= {qr[DW-2:0], 1'b0};
      end
      cnt <= cnt - CW'(1);
    end
  end

  always_comb begin
    res.done = (state == DV_FIN);
    if (zero) begin
      res.value = '0;
      res.fault = FAULT_ZERO;
    end else if (neg) begin
      res.value = neg_ovf ? 32'sh8000_0000 : 32'(-qr[31:0]);
      res.fault = neg_ovf ? FAULT_SAT : FAULT_OK;
    end else begin
      res.value = pos_ovf ? 32'sh7fff_ffff : qr[31:0];
      res.fault = pos_ovf ? FAULT_SAT : FAULT_OK;
    end
  end

endmodule

FILE: hw/rtl/hermite_divided_difference_table_core.sv
// ----------------------------------------------------------------------------
// hermite_divided_difference_table_core
// Hermite divided-difference table in signed Q16.16, one node per word.
//
//   channel  dir  word
//   s_*      in   one node: x, f, f'; tlast marks the final node of a set
//   m_*      out  one table entry; tlast marks the last entry of the node
//
// Node i gives 4i+3 entries; 4i of them wait on the bit-serial divider, which
// goes straight to its result on a zero denominator. Each row pass steps the
// row chain through all 2*MAX_NODES slots.
// One node at a time.
// Reset clears control only. A stalled output holds the engine at its next entry.
// ----------------------------------------------------------------------------
module hermite_divided_difference_table_core #(
  parameter int MAX_NODES = 16,
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,   // node_x, node_value, node_slope
  input  logic        s_tlast,   // last_node
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,   // row_index, column_index, row_abscissa,
                                 // entry_value, fault, 4 bits zero
  output logic        m_tlast    // last_of_run
);
  import hdd_pkg::*;

  localparam int ROWS = 2 * MAX_NODES;
  localparam int SW   = $clog2(ROWS);
  localparam int NW   = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

  state_t             state, state_next;
  logic               odd_pass;
  logic [SW-1:0]      slot;
  logic [SW-1:0]      len;
  logic [NW-1:0]      node_cnt;
  logic [NW-1:0]      node_idx;
  logic [31:0]        in_x;
  logic [31:0]        in_f;
  logic [31:0]        in_fp;
  logic               in_last;
  logic [31:0]        cur;
  fault_t             cur_fault;
  logic [31:0]        abs_mem [MAX_NODES];
  logic [31:0]        cell_q [ROWS];
  logic [31:0]        head;
  logic [31:0]        z_val;
  logic [SW-1:0]      row_sw;
  logic [SW-1:0]      slot_plus;
  logic [NW-1:0]      zidx;
  logic signed [32:0] num;
  logic signed [32:0] den;
  div_res_t           dres;

  logic [4:0]         out_row;
  logic [4:0]         out_col;
  logic [31:0]        out_absc;
  logic [31:0]        out_val;
  fault_t             out_fault;
  logic               out_last;

  logic out_free, in_row, emit, rot, dstart, adv, take_fp, pass_end;

  assign head      = cell_q[0];
  assign row_sw    = SW'({node_idx, odd_pass});
  assign slot_plus = slot + SW'(1);
  assign zidx      = NW'((row_sw - slot_plus) >> 1);
  assign z_val     = abs_mem[zidx];
  assign num       = {cur[31], cur} - {head[31], head};
  assign den       = {in_x[31], in_x} - {z_val[31], z_val};
  assign out_free  = !m_tvalid || m_tready;
  assign in_row    = (slot <= len);
  assign s_tready  = (state == ST_IDLE);

  for (genvar k = 0; k < ROWS; k++) begin : g_chain
    hdd_cell u_cell (
      .clk       (clk),
      .en        (rot),
      .load      ((k == ROWS - 1) && emit),
      .load_data (cur),
      .nb_data   (cell_q[(k + 1) % ROWS]),
      .q         (cell_q[k])
    );
  end

  hdd_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (dstart),
    .num   (num),
    .den   (den),
    .res   (dres)
  );

  always_comb begin
    emit    = 1'b0;
    rot     = 1'b0;
    dstart  = 1'b0;
    adv     = 1'b0;
    take_fp = 1'b0;
    unique case (state)
      ST_SLOT: begin
        if (in_row) begin
          if (out_free) begin
            emit = 1'b1;
            rot  = 1'b1;
            if (slot < len) begin
              if (odd_pass && slot == '0) begin
                take_fp = 1'b1;
                adv     = 1'b1;
              end else begin
                dstart = 1'b1;
              end
            end else begin
              adv = 1'b1;
            end
          end
        end else begin
          rot = 1'b1;
          adv = 1'b1;
        end
      end
      default: ;
    endcase
    pass_end = adv && (slot == SW'(ROWS - 1));
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (s_tvalid) state_next = ST_SLOT;
      ST_SLOT: begin
        if (dstart) state_next = ST_DIV;
        else if (pass_end && odd_pass) state_next = ST_IDLE;
      end
      ST_DIV:  if (dres.done) state_next = ST_SLOT;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
      node_cnt <= '0;
    end else begin
      state <= state_next;
      if (emit) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      if (state == ST_SLOT && pass_end && odd_pass) begin
        if (in_last || node_idx == NW'(MAX_NODES - 1)) node_cnt <= '0;
        else node_cnt <= node_idx + NW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_tvalid) begin
      node_idx          <= node_cnt;
      abs_mem[node_cnt] <= s_tdata[31:0];
      in_x              <= s_tdata[31:0];
      in_f              <= s_tdata[63:32];
      in_fp             <= s_tdata[95:64];
      in_last           <= s_tlast;
      odd_pass          <= 1'b0;
      slot              <= '0;
      len               <= SW'({node_cnt, 1'b0});
      cur               <= s_tdata[63:32];
      cur_fault         <= FAULT_OK;
    end else if (state == ST_DIV) begin
      if (dres.done) begin
        cur       <= dres.value;
        cur_fault <= dres.fault;
        slot      <= slot_plus;
      end
    end else if (state == ST_SLOT) begin
      if (pass_end) begin
        odd_pass  <= 1'b1;
        slot      <= '0;
        len       <= SW'({node_idx, 1'b1});
        cur       <= in_f;
        cur_fault <= FAULT_OK;
      end else if (adv) begin
        slot <= slot_plus;
        if (take_fp) begin
          cur       <= in_fp;
          cur_fault <= FAULT_OK;
        end
      end
    end
    if (emit) begin
      out_row   <= 5'({node_idx, odd_pass});
      out_col   <= 5'(slot);
      out_absc  <= in_x;
      out_val   <= cur;
      out_fault <= cur_fault;
      out_last  <= odd_pass && (slot == len);
    end
  end

  assign m_tdata = {4'b0000, out_fault, out_val, out_absc, out_col, out_row};
  assign m_tlast = out_last;

  a_copy_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_col == 5'd0 |-> out_fault == FAULT_OK)
    else $error("column 0 entry carries a fault");

  a_last_odd: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> out_row[0])
    else $error("run ends on an even row");

  a_col_row: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> out_col <= out_row)
    else $error("column exceeds row");

  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    dres.done |-> state == ST_DIV)
    else $error("divider result with no entry waiting");

endmodule

FILE: verif/hdd_table_checker.sv
// ----------------------------------------------------------------------------
// hdd_table_checker
// Watches both streams, rebuilds the Hermite divided-difference table in
// Q16.16 for every accepted node and compares each emitted entry in order.
// ----------------------------------------------------------------------------
module hdd_table_checker #(
  parameter int MAX_NODES = 16,
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [95:0] s_tdata,
  input  logic        s_tlast,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [79:0] m_tdata,
  input  logic        m_tlast,
  output int          fail_count,
  output int          entries_pending
);
  import hdd_pkg::*;

  typedef struct packed {
    logic [4:0]         row;
    logic [4:0]         col;
    logic signed [31:0] z;
    logic signed [31:0] value;
    fault_t             fault;
    logic               last;
  } table_entry_t;

  table_entry_t entry_queue[$];
  logic signed [31:0] node_xs [MAX_NODES];
  logic signed [31:0] prior_row [2*MAX_NODES];
  int unsigned node_idx;

  assign entries_pending = entry_queue.size();

  function automatic logic signed [31:0] q_divide(input logic signed [63:0] num,
                                                  input logic signed [63:0] den,
                                                  output fault_t flt);
    logic signed [63:0] q;
    if (den == 0) begin
      flt = FAULT_ZERO;
      return 0;
    end
    q = (num <<< FRAC_BITS) / den;
    if (q > 64'sd2147483647) begin
      flt = FAULT_SAT;
      return 32'h7fffffff;
    end
    if (q < -64'sd2147483648) begin
      flt = FAULT_SAT;
      return 32'h80000000;
    end
    flt = FAULT_OK;
    return q[31:0];
  endfunction

  task automatic build_node_rows(input logic signed [31:0] x,
                                 input logic signed [31:0] f,
                                 input logic signed [31:0] fp,
                                 input logic last_node);
    logic signed [31:0] even_row [2*MAX_NODES];
    logic signed [31:0] odd_row [2*MAX_NODES];
    int re, ro;
    fault_t flt;
    re = 2 * node_idx;
    ro = re + 1;
    node_xs[node_idx] = x;
    even_row[0] = f;
    entry_queue.push_back('{re[4:0], 5'd0, x, f, FAULT_OK, 1'b0});
    for (int j = 1; j <= re; j++) begin
      even_row[j] = q_divide(64'(even_row[j-1]) - 64'(prior_row[j-1]),
                             64'(x) - 64'(node_xs[(re-j)/2]), flt);
      entry_queue.push_back('{re[4:0], j[4:0], x, even_row[j], flt, 1'b0});
    end
    odd_row[0] = f;
    odd_row[1] = fp;
    entry_queue.push_back('{ro[4:0], 5'd0, x, f, FAULT_OK, 1'b0});
    entry_queue.push_back('{ro[4:0], 5'd1, x, fp, FAULT_OK, ro == 1});
    for (int j = 2; j <= ro; j++) begin
      odd_row[j] = q_divide(64'(odd_row[j-1]) - 64'(even_row[j-1]),
                            64'(x) - 64'(node_xs[(ro-j)/2]), flt);
      entry_queue.push_back('{ro[4:0], j[4:0], x, odd_row[j], flt, j == ro});
    end
    for (int j = 0; j <= ro; j++) prior_row[j] = odd_row[j];
    if (last_node || node_idx + 1 >= MAX_NODES) node_idx = 0;
    else node_idx = node_idx + 1;
  endtask

  always @(posedge clk) begin
    table_entry_t exp_e;
    table_entry_t got;
    if (rst) begin
      node_idx = 0;
      fail_count = 0;
      entry_queue.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got = '{m_tdata[4:0], m_tdata[9:5], m_tdata[41:10], m_tdata[73:42],
                fault_t'(m_tdata[75:74]), m_tlast};
        if (entry_queue.size() == 0) begin
          fail_count++;
          $display("%0t unexpected word %h", $time, got);
        end else begin
          exp_e = entry_queue.pop_front();
          if (got !== exp_e) begin
            fail_count++;
            $display("%0t mismatch r%0d c%0d: expected z=%h v=%h f=%0d l=%b",
                     $time, exp_e.row, exp_e.col, exp_e.z, exp_e.value,
                     exp_e.fault, exp_e.last);
            $display("%0t   actual r%0d c%0d z=%h v=%h f=%0d l=%b", $time,
                     got.row, got.col, got.z, got.value, got.fault, got.last);
          end
        end
      end
      if (s_tvalid && s_tready)
        build_node_rows(s_tdata[31:0], s_tdata[63:32], s_tdata[95:64], s_tlast);
    end
  end

endmodule

FILE: verif/tb_hermite_divided_difference_table_core.sv
// ----------------------------------------------------------------------------
// tb_hermite_divided_difference_table_core
// Streams node sets into the core with random gaps and output stalls; the
// checker predicts every table entry and counts mismatches.
// ----------------------------------------------------------------------------
module tb_hermite_divided_difference_table_core;
  import hdd_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [95:0] s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [79:0] m_tdata;
  logic        m_tlast;
  int          fail_count;
  int          entries_pending;
  logic [31:0] used_x[$];
  int          set_pos;
  int          out_wait;

  always #5 clk = ~clk;

  hermite_divided_difference_table_core u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  hdd_table_checker u_chk (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .fail_count(fail_count), .entries_pending(entries_pending)
  );

  task automatic send_node(input logic [31:0] x, input logic [31:0] f,
                           input logic [31:0] fp, input logic last_node);
    int gap;
    gap = $urandom_range(0, 13);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {fp, f, x};
    s_tlast  <= last_node;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (last_node || set_pos == 15) set_pos = 0;
    else set_pos++;
  endtask

  function automatic logic [31:0] rand_word(input int kind);
    case (kind)
      0: return $urandom();
      1: return $urandom_range(0, 32'h0003ffff) - 32'h00020000;
      2: return $urandom_range(0, 255) << 12;
      default: return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom())};
    endcase
  endfunction

  // after an accepted word, ready drops unless a random draw comes out zero
  always @(posedge clk) begin
    int w;
    w = $urandom_range(0, 13);
    if (rst) begin
      m_tready <= 1'b0;
      out_wait <= 0;
    end else if (m_tvalid && m_tready) begin
      m_tready <= (w == 0);
      out_wait <= w;
    end else if (out_wait > 0) begin
      m_tready <= (out_wait == 1);
      out_wait <= out_wait - 1;
    end else begin
      m_tready <= 1'b1;
    end
  end

  initial begin
    logic [31:0] x;
    int set_len;
    int n;
    set_pos = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: extremes, repeated abscissa, saturation, full set
    send_node(32'h80000000, 32'h7fffffff, 32'h80000000, 1'b0);
    send_node(32'h7fffffff, 32'h80000000, 32'h7fffffff, 1'b0);
    send_node(32'h00000001, 32'h7fffffff, 32'h80000000, 1'b1);
    send_node(32'h00010000, 32'h00020000, 32'hffff0000, 1'b0);
    send_node(32'h00010000, 32'h00030000, 32'h00010000, 1'b1);
    send_node(32'hffffffff, 32'h00000000, 32'h00000000, 1'b1);
    for (int i = 0; i < 16; i++)
      send_node(32'(i * 32'h00008000 - 32'h00040000), $urandom(), $urandom(), 1'b0);
    n = 0;
    while (n < 280) begin
      set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 16) : $urandom_range(1, 5);
      used_x.delete();
      for (int k = 0; k < set_len && n < 280; k++) begin
        x = rand_word($urandom_range(0, 3));
        if ($urandom_range(0, 19) == 0 && used_x.size() > 0)
          x = used_x[$urandom_range(0, used_x.size() - 1)];
        used_x.push_back(x);
        send_node(x, rand_word($urandom_range(0, 3)), rand_word($urandom_range(0, 3)),
                  k == set_len - 1);
        n++;
        if (set_pos == 0) break;
      end
    end
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (entries_pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #60000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
